[rtl/cbtr_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbtr_pkg: shared types and constants for the tone-range color balance
// Fixed-point formats, mask offsets, lane structs and the pipeline depth.
// ---------------------------------------------------------------------------
package cbtr_pkg;

  localparam int FRAC_BITS = 12;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = ONE / 2;
  localparam int B4        = (8 * ONE + 3) / 6;         // round(4/3 * ONE)
  localparam int NLANE     = 3;
  localparam int PIX_W     = 8;
  localparam int CW        = 10;                        // correction width
  localparam int REG_W     = NLANE * CW;

  // channel / mask width, values in [0, ONE]
  localparam int PW        = FRAC_BITS + 1;
  // signed width for the raw mask ramps
  localparam int LW        = FRAC_BITS + 4;

  // 8-bit to fixed point: p = floor((c*ONE + 127) / 255) by reciprocal
  localparam int NW        = PIX_W + FRAC_BITS;
  localparam int RK        = NW + 8;
  localparam int RW        = RK - 7;
  localparam int PRW       = NW + RW;
  localparam longint unsigned RECIP = ((64'd1 << RK) + 64'd254) / 64'd255;
  localparam int RND255    = 127;

  localparam logic signed [LW-1:0] MS_OFF = LW'(HALF + B4);
  localparam logic signed [LW-1:0] M1_OFF = LW'(B4 - HALF);
  localparam logic signed [LW-1:0] M2_OFF = LW'(4 * ONE - B4 + HALF);
  localparam logic signed [LW-1:0] MH_OFF = LW'(4 * ONE - B4 - HALF);

  localparam logic [FRAC_BITS-1:0] SCALE = FRAC_BITS'((7 * ONE + 5) / 10);

  localparam int CPW       = CW + PW + 1;               // correction x mask
  localparam int SUMW      = CPW + 2;                   // sum of three
  localparam int SCW       = SUMW + FRAC_BITS + 1;      // times scale
  localparam int TOTW      = SCW + 1;                   // plus base
  localparam int DSH       = 8 + 2 * FRAC_BITS;         // log2 of full scale
  localparam int CLW       = DSH + 1;                   // clamped sum

  localparam int NSTAGE    = 7;

  typedef enum logic [1:0] {
    CFG_SHADOW    = 2'd0,
    CFG_MIDTONE   = 2'd1,
    CFG_HIGHLIGHT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [PW-1:0] ms;
    logic [PW-1:0] mm;
    logic [PW-1:0] mh;
  } mask_t;

  typedef struct packed {
    logic signed [CW-1:0] cs;
    logic signed [CW-1:0] cm;
    logic signed [CW-1:0] ch;
  } corr_t;

  function automatic logic [PW-1:0] clamp_one(logic signed [LW-1:0] x);
    logic [PW-1:0] r;
    if (x < 0) begin
      r = '0;
    end else if (x > LW'(ONE)) begin
      r = PW'(ONE);
    end else begin
      r = x[PW-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/color_balance_tone_ranges.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// color_balance_tone_ranges: shadow / midtone / highlight color balance
//
// One RGB pixel word enters on the s_axis channel, one balanced pixel word
// leaves on the m_axis channel; both are 24-bit words, red in the low byte.
// Lightness (max+min)/2 sets three ramp masks; each channel adds its own
// shadow, midtone and highlight corrections weighted by them, scaled by
// 0.7, then the result is clamped to [0,1] and rounded back to 8 bits.
// Corrections come from three 30-bit registers on the cfg port (signed
// 10-bit fields, red low); write them only while the pipe is empty.
// Throughput: one word per clock while the receiver keeps m_axis_tready
// high. A word runs through the 7-stage pipe (normalize, masks, midtone
// product, weight multiplies, scale multiply, clamp, round) and then
// raises m_axis_tvalid.
// Each stage holds its own valid bit; when the receiver stalls the words
// pile up behind the output register, bubbles are squeezed out, and
// s_axis_tready drops only once every stage is full.
// Reset empties the pipe and clears all corrections to zero.
// ---------------------------------------------------------------------------
module color_balance_tone_ranges (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,   // in_red, in_green, in_blue
  // stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,   // out_red, out_green, out_blue
  // configuration
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [cbtr_pkg::REG_W-1:0]    cfg_data_i
);

  localparam int N = cbtr_pkg::NSTAGE;

  logic [cbtr_pkg::REG_W-1:0] shadow_q, midtone_q, highlight_q;
  logic [N-1:0]               vld_d, vld_q, rdy;
  logic [cbtr_pkg::NLANE-1:0][cbtr_pkg::PW-1:0] p;
  cbtr_pkg::mask_t            mask;

  // correction registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_q    <= '0;
      midtone_q   <= '0;
      highlight_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cbtr_pkg::CFG_SHADOW:    shadow_q    <= cfg_data_i;
        cbtr_pkg::CFG_MIDTONE:   midtone_q   <= cfg_data_i;
        cbtr_pkg::CFG_HIGHLIGHT: highlight_q <= cfg_data_i;
        default: ;  // unused index, ignored
      endcase
    end
  end

  // a stage loads when it is empty or its successor moves on
  always_comb begin
    rdy[N-1] = !vld_q[N-1] || m_axis_tready;
    for (int k = N - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = rdy[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < N; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[N-1];

  // per-channel lanes
  for (genvar k = 0; k < cbtr_pkg::NLANE; k++) begin : g_lane
    cbtr_pkg::corr_t corr;

    assign corr.cs = shadow_q[k*cbtr_pkg::CW +: cbtr_pkg::CW];
    assign corr.cm = midtone_q[k*cbtr_pkg::CW +: cbtr_pkg::CW];
    assign corr.ch = highlight_q[k*cbtr_pkg::CW +: cbtr_pkg::CW];

    cbtr_norm u_norm (
      .clk_i (clk_i),
      .en_i  (rdy[0]),
      .c_i   (s_axis_tdata[k*cbtr_pkg::PIX_W +: cbtr_pkg::PIX_W]),
      .p_o   (p[k])
    );

    cbtr_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (rdy),
      .p_i    (p[k]),
      .mask_i (mask),
      .corr_i (corr),
      .out_o  (m_axis_tdata[k*cbtr_pkg::PIX_W +: cbtr_pkg::PIX_W])
    );
  end

  // lightness and masks, shared by all lanes
  cbtr_mask u_mask (
    .clk_i  (clk_i),
    .en_i   (rdy[2:1]),
    .p_i    (p),
    .mask_o (mask)
  );

  // ready low means every stage holds a word
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&vld_q))
    else $error("input blocked with a bubble in the pipe");

  // an accepted word lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted word lost at entry");

  // output valid only rises when the stage behind it held a word
  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(vld_q[N-1]) |-> $past(vld_q[N-2]))
    else $error("output word appeared from nowhere");

endmodule

[rtl/cbtr_norm.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbtr_norm: 8-bit channel to fixed point
// p = round(c * ONE / 255) via exact reciprocal multiply, registered.
// ---------------------------------------------------------------------------
module cbtr_norm (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [cbtr_pkg::PIX_W-1:0] c_i,
  output logic [cbtr_pkg::PW-1:0] p_o
);

  logic [cbtr_pkg::NW-1:0]  n;
  logic [cbtr_pkg::PRW-1:0] prod;
  logic [cbtr_pkg::PW-1:0]  p_d, p_q;

  assign n    = {c_i, {cbtr_pkg::FRAC_BITS{1'b0}}} + cbtr_pkg::NW'(cbtr_pkg::RND255);
  assign prod = cbtr_pkg::PRW'(n) * cbtr_pkg::PRW'(cbtr_pkg::RECIP);
  assign p_d  = prod[cbtr_pkg::RK +: cbtr_pkg::PW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

[rtl/cbtr_mask.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbtr_mask: lightness and tone-range masks
// Merges the three lanes: l = (max+min)/2, ramp masks, midtone product.
// ---------------------------------------------------------------------------
module cbtr_mask (
  input  logic                                 clk_i,
  input  logic [1:0]                           en_i,   // [0] ramps, [1] midtone
  input  logic [cbtr_pkg::NLANE-1:0][cbtr_pkg::PW-1:0] p_i,
  output cbtr_pkg::mask_t                      mask_o
);

  logic [cbtr_pkg::PW-1:0]        hi, lo, l;
  logic [cbtr_pkg::PW:0]          hl_sum;
  logic signed [cbtr_pkg::LW-1:0] l4;
  logic [cbtr_pkg::PW-1:0]        ms_q, m1_q, m2_q, mh_q;
  logic [2*cbtr_pkg::PW-1:0]      mm_prod;
  cbtr_pkg::mask_t                mask_q;

  always_comb begin
    hi = p_i[0];
    lo = p_i[0];
    for (int k = 1; k < cbtr_pkg::NLANE; k++) begin
      if (p_i[k] > hi) hi = p_i[k];
      if (p_i[k] < lo) lo = p_i[k];
    end
  end

  assign hl_sum = {1'b0, hi} + {1'b0, lo};
  assign l      = hl_sum[cbtr_pkg::PW:1];
  assign l4     = $signed({1'b0, l, 2'b00});

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ms_q <= cbtr_pkg::clamp_one(cbtr_pkg::MS_OFF - l4);
      m1_q <= cbtr_pkg::clamp_one(l4 - cbtr_pkg::M1_OFF);
      m2_q <= cbtr_pkg::clamp_one(cbtr_pkg::M2_OFF - l4);
      mh_q <= cbtr_pkg::clamp_one(l4 - cbtr_pkg::MH_OFF);
    end
  end

  assign mm_prod = (2*cbtr_pkg::PW)'(m1_q) * (2*cbtr_pkg::PW)'(m2_q)
                 + (2*cbtr_pkg::PW)'(cbtr_pkg::HALF);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      mask_q.ms <= ms_q;
      mask_q.mm <= mm_prod[cbtr_pkg::FRAC_BITS +: cbtr_pkg::PW];
      mask_q.mh <= mh_q;
    end
  end

  assign mask_o = mask_q;

endmodule

[rtl/cbtr_lane.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbtr_lane: per-channel correction datapath
// Weighted corrections, 0.7 scale, add to base, clamp, round to 8 bits.
// ---------------------------------------------------------------------------
module cbtr_lane (
  input  logic                          clk_i,
  input  logic [cbtr_pkg::NSTAGE-1:0]   en_i,
  input  logic [cbtr_pkg::PW-1:0]       p_i,     // stage 0 output
  input  cbtr_pkg::mask_t               mask_i,  // stage 2 output
  input  cbtr_pkg::corr_t               corr_i,
  output logic [cbtr_pkg::PIX_W-1:0]    out_o
);

  localparam int RNDW = cbtr_pkg::DSH + 9;

  logic [cbtr_pkg::PW-1:0]          pd_q [1:4];
  logic signed [cbtr_pkg::CPW-1:0]  ps_q, pm_q, ph_q;
  logic signed [cbtr_pkg::SUMW-1:0] corr_sum;
  logic signed [cbtr_pkg::SCW-1:0]  scaled_q;
  logic signed [cbtr_pkg::TOTW-1:0] base, total, den;
  logic [cbtr_pkg::CLW-1:0]         clamped_d, clamped_q;
  logic [RNDW-1:0]                  rnd;
  logic [cbtr_pkg::PIX_W-1:0]       out_q;

  // base channel value follows the pipeline
  always_ff @(posedge clk_i) begin
    if (en_i[1]) pd_q[1] <= p_i;
    if (en_i[2]) pd_q[2] <= pd_q[1];
    if (en_i[3]) pd_q[3] <= pd_q[2];
    if (en_i[4]) pd_q[4] <= pd_q[3];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      ps_q <= corr_i.cs * $signed({1'b0, mask_i.ms});
      pm_q <= corr_i.cm * $signed({1'b0, mask_i.mm});
      ph_q <= corr_i.ch * $signed({1'b0, mask_i.mh});
    end
  end

  assign corr_sum = cbtr_pkg::SUMW'(ps_q) + cbtr_pkg::SUMW'(pm_q) + cbtr_pkg::SUMW'(ph_q);

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      scaled_q <= cbtr_pkg::SCW'(corr_sum) * $signed({1'b0, cbtr_pkg::SCALE});
    end
  end

  assign base  = cbtr_pkg::TOTW'($signed({1'b0, pd_q[4], {(cbtr_pkg::FRAC_BITS + 8){1'b0}}}));
  assign total = base + cbtr_pkg::TOTW'(scaled_q);
  assign den   = $signed({{(cbtr_pkg::TOTW - cbtr_pkg::DSH - 1){1'b0}}, 1'b1,
                          {cbtr_pkg::DSH{1'b0}}});

  always_comb begin
    priority if (total < 0) begin
      clamped_d = '0;
    end else if (total > den) begin
      clamped_d = den[cbtr_pkg::CLW-1:0];
    end else begin
      clamped_d = total[cbtr_pkg::CLW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      clamped_q <= clamped_d;
    end
  end

  // sum*255 + D/2, keep the integer part
  assign rnd = {clamped_q, 8'd0} - {8'd0, clamped_q}
             + RNDW'({1'b1, {(cbtr_pkg::DSH - 1){1'b0}}});

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      out_q <= rnd[cbtr_pkg::DSH +: cbtr_pkg::PIX_W];
    end
  end

  assign out_o = out_q;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the tone-range color balance block
// Sends directed and random RGB words with random gaps and stalls on both
// stream sides and steps through several correction settings, the extremes
// among them. Each output word is predicted in fixed point and compared,
// in order and channel by channel, with what the block returns.
// ---------------------------------------------------------------------------
module tb_top;

  // fixed-point constants of the predictor
  localparam int     FRAC     = cbtr_pkg::FRAC_BITS;
  localparam longint ONE_FX   = longint'(1) << FRAC;
  localparam longint HALF_FX  = ONE_FX / 2;
  localparam longint B4_FX    = (8 * ONE_FX + 3) / 6;       // 4/3, rounded
  localparam longint SCALE_FX = (7 * ONE_FX + 5) / 10;      // 0.7, rounded
  localparam int     DSHIFT   = 8 + 2 * FRAC;
  localparam longint FULL_FX  = longint'(1) << DSHIFT;      // 1.0 of the wide sum

  // index 3 decodes to no register; a write there must change nothing
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic [9:0] POS_MAX    = 10'h1FF;              // +511/256
  localparam logic [9:0] NEG_MAX    = 10'h200;              // -512/256

  localparam int N_PHASES    = 6;
  localparam int PHASE_WORDS = 325;
  localparam int PIPE_DEPTH  = 7;

  // one pixel word, red in the low byte as on the bus
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct packed {
    rgb_t src;
    rgb_t want;
  } balance_rec_t;

  // -------------------------------------------------------------------------
  // Scoreboard: mirrors the three correction registers, predicts the
  // balanced word for every accepted source word and checks the outputs
  // -------------------------------------------------------------------------
  class tone_balance_sb;
    logic [29:0]  shadow_reg;
    logic [29:0]  midtone_reg;
    logic [29:0]  highlight_reg;
    balance_rec_t awaited [$];
    int           errors;
    int           noted;
    int           checked;
    string        lane_tag [3];

    function new();
      shadow_reg    = '0;
      midtone_reg   = '0;
      highlight_reg = '0;
      errors        = 0;
      noted         = 0;
      checked       = 0;
      lane_tag      = '{"red", "green", "blue"};
    endfunction

    function void set_reg(logic [1:0] idx, logic [29:0] val);
      case (idx)
        cbtr_pkg::CFG_SHADOW:    shadow_reg    = val;
        cbtr_pkg::CFG_MIDTONE:   midtone_reg   = val;
        cbtr_pkg::CFG_HIGHLIGHT: highlight_reg = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function longint clamp_unit(longint x);
      if (x < 0) return 0;
      if (x > ONE_FX) return ONE_FX;
      return x;
    endfunction

    function rgb_t balanced_pixel(rgb_t src);
      logic [7:0]        chan [3];
      logic [7:0]        res [3];
      longint            lvl [3];
      longint            hi, lo, lt, ms, m1, m2, mm, mh, corr, acc;
      logic signed [9:0] cs, cm, ch;
      chan[0] = src.red;
      chan[1] = src.green;
      chan[2] = src.blue;
      for (int k = 0; k < 3; k++) begin
        lvl[k] = (longint'(chan[k]) * ONE_FX * 2 + 255) / 510;
      end
      hi = lvl[0];
      lo = lvl[0];
      for (int k = 1; k < 3; k++) begin
        if (lvl[k] > hi) hi = lvl[k];
        if (lvl[k] < lo) lo = lvl[k];
      end
      lt = (hi + lo) >>> 1;
      // ramp masks over lightness
      ms = clamp_unit(HALF_FX + B4_FX - 4 * lt);
      m1 = clamp_unit(4 * lt - B4_FX + HALF_FX);
      m2 = clamp_unit(4 * ONE_FX - B4_FX + HALF_FX - 4 * lt);
      mm = (m1 * m2 + HALF_FX) >>> FRAC;
      mh = clamp_unit(4 * lt - 4 * ONE_FX + B4_FX + HALF_FX);
      for (int k = 0; k < 3; k++) begin
        cs   = shadow_reg[10*k +: 10];
        cm   = midtone_reg[10*k +: 10];
        ch   = highlight_reg[10*k +: 10];
        corr = longint'(cs) * ms + longint'(cm) * mm + longint'(ch) * mh;
        acc  = lvl[k] * 256 * ONE_FX + corr * SCALE_FX;
        if (acc < 0) acc = 0;
        if (acc > FULL_FX) acc = FULL_FX;
        res[k] = 8'((acc * 255 + FULL_FX / 2) >>> DSHIFT);
      end
      return {res[2], res[1], res[0]};
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function void note_source(rgb_t px);
      balance_rec_t rec;
      rec.src  = px;
      rec.want = balanced_pixel(px);
      awaited.push_back(rec);
      noted++;
    endfunction

    task check_balanced(rgb_t got);
      balance_rec_t rec;
      if (awaited.size() == 0) begin
        report($sformatf("word %06h with nothing awaited", got));
        return;
      end
      rec = awaited.pop_front();
      checked++;
      for (int k = 0; k < 3; k++) begin
        if (got[8*k +: 8] !== rec.want[8*k +: 8]) begin
          report($sformatf("%s of source %06h: got %02h, expected %02h",
                           lane_tag[k], rec.src, got[8*k +: 8], rec.want[8*k +: 8]));
        end
      end
    endtask
  endclass

  // -------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // -------------------------------------------------------------------------
  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [23:0]                s_axis_tdata  = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [23:0]                m_axis_tdata;
  logic                       cfg_we_i      = 1'b0;
  logic [1:0]                 cfg_idx_i     = '0;
  logic [cbtr_pkg::REG_W-1:0] cfg_data_i    = '0;

  tone_balance_sb sb;
  bit             steady = 1'b0;    // when set, neither side idles
  int             settings_seen = 0;

  color_balance_tone_ranges dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // -------------------------------------------------------------------------
  // Monitor: handshake signals are read right at the edge, so both see the
  // values from before it (everything driven here and in the DUT is NBA)
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_balanced(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_source(s_axis_tdata);
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: random stall before taking each word
  // -------------------------------------------------------------------------
  initial begin : sink
    int stall;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------

  // Returns at the edge where the word was taken; tvalid stays up so the
  // next word can follow without a bubble.
  task automatic send_pixel(rgb_t px);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop sending and wait until every predicted word has come back.
  // The first edge lets the monitor log the last accepted word.
  task automatic settle(int extra);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Back-to-back writes: we stays high, the caller lowers it once.
  task automatic put_reg(logic [1:0] idx, logic [29:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic load_corrections(logic [29:0] sh, logic [29:0] mid, logic [29:0] hl,
                                  bit poke_unused);
    put_reg(cbtr_pkg::CFG_SHADOW, sh);
    put_reg(cbtr_pkg::CFG_MIDTONE, mid);
    put_reg(cbtr_pkg::CFG_HIGHLIGHT, hl);
    if (poke_unused) put_reg(CFG_UNUSED, 30'($urandom));
    cfg_we_i <= 1'b0;
    settings_seen++;
  endtask

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  function automatic rgb_t mk_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return {b, g, r};
  endfunction

  // Mix of uniform colors, grays (walk the lightness ramps), channels
  // pinned at 0/255, and tight clusters where max and min sit close.
  function automatic rgb_t random_pixel();
    logic [7:0] ch [3];
    logic [7:0] base;
    int         mode;
    int         v;
    mode = $urandom_range(0, 3);
    base = 8'($urandom);
    for (int k = 0; k < 3; k++) begin
      case (mode)
        0: ch[k] = 8'($urandom);
        1: ch[k] = base;
        2: ch[k] = ($urandom_range(0, 2) == 0) ? 8'($urandom)
                                               : {8{$urandom_range(0, 1) == 1}};
        default: begin
          v     = int'(base) + int'($urandom_range(0, 8)) - 4;
          ch[k] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
        end
      endcase
    end
    return {ch[2], ch[1], ch[0]};
  endfunction

  // Full-range lanes saturate a lot; the gentle ones, within +-40, saturate less often.
  function automatic logic [29:0] random_corrections();
    logic [9:0] lane [3];
    int         pick;
    pick = $urandom_range(0, 2);
    for (int k = 0; k < 3; k++) begin
      case (pick)
        0: lane[k] = 10'($urandom);
        1: begin
          case ($urandom_range(0, 2))
            0:       lane[k] = POS_MAX;
            1:       lane[k] = NEG_MAX;
            default: lane[k] = 10'($urandom);
          endcase
        end
        default: lane[k] = 10'(int'($urandom_range(0, 80)) - 40);
      endcase
    end
    return {lane[2], lane[1], lane[0]};
  endfunction

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : stimulus
    rgb_t        probe [$];
    logic [29:0] pos_all;
    logic [29:0] neg_all;
    pos_all = {3{POS_MAX}};
    neg_all = {3{NEG_MAX}};
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corrections at their reset value: pixels pass through unchanged
    probe = '{mk_rgb(8'h00, 8'h00, 8'h00), mk_rgb(8'hFF, 8'hFF, 8'hFF),
              mk_rgb(8'h80, 8'h40, 8'hC0)};
    foreach (probe[i]) send_pixel(probe[i]);
    settle(PIPE_DEPTH + 1);

    // strongest positive push everywhere, plus a write to the unused index;
    // primaries, grays across both ramp centers, near-extreme mixes
    load_corrections(pos_all, pos_all, pos_all, 1'b1);
    probe = '{mk_rgb(8'h00, 8'h00, 8'h00), mk_rgb(8'hFF, 8'hFF, 8'hFF),
              mk_rgb(8'hFF, 8'h00, 8'h00), mk_rgb(8'h00, 8'hFF, 8'h00),
              mk_rgb(8'h00, 8'h00, 8'hFF), mk_rgb(8'h35, 8'h35, 8'h35),
              mk_rgb(8'h55, 8'h55, 8'h55), mk_rgb(8'h75, 8'h75, 8'h75),
              mk_rgb(8'h80, 8'h80, 8'h80), mk_rgb(8'hAA, 8'hAA, 8'hAA),
              mk_rgb(8'hCA, 8'hCA, 8'hCA), mk_rgb(8'h01, 8'hFE, 8'h7F)};
    foreach (probe[i]) send_pixel(probe[i]);
    settle(PIPE_DEPTH + 1);

    // strongest negative pull: drives outputs into the low clamp
    load_corrections(neg_all, neg_all, neg_all, 1'b1);
    probe = '{mk_rgb(8'h00, 8'h00, 8'h00), mk_rgb(8'hFF, 8'hFF, 8'hFF),
              mk_rgb(8'h55, 8'h55, 8'h55), mk_rgb(8'h80, 8'h80, 8'h80),
              mk_rgb(8'hAA, 8'hAA, 8'hAA), mk_rgb(8'hFE, 8'h01, 8'h80)};
    foreach (probe[i]) send_pixel(probe[i]);
    settle(PIPE_DEPTH + 1);

    // random phases, each under its own correction setting
    for (int phase = 0; phase < N_PHASES; phase++) begin
      case (phase)
        0:       load_corrections(pos_all, neg_all, pos_all, 1'b0);
        1:       load_corrections(neg_all, pos_all, neg_all, 1'b1);
        default: load_corrections(random_corrections(), random_corrections(),
                                  random_corrections(), $urandom_range(0, 1) == 1);
      endcase
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // stretches with no idling on either side now and then
        if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
        // sender holds off once until the pipe has fully drained
        if (phase == 2 && i == 160) settle(0);
        send_pixel(random_pixel());
      end
      settle(PIPE_DEPTH + 1);
    end

    settle(PIPE_DEPTH + 4);
    $display("Run covered %0d pixel words under %0d correction settings; %0d words checked.",
             sb.noted, settings_seen, sb.checked);
    $display("Settings included all-max, all-min and mixed-sign corrections.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS color_balance_tone_ranges");
    end else begin
      $display("FAIL color_balance_tone_ranges");
    end
    $finish;
  end

  // hard stop: far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("Timeout: stream stopped moving");
    $display("FAIL color_balance_tone_ranges");
    $finish;
  end

endmodule

[color_balance_tone_ranges.f]
rtl/cbtr_pkg.sv
rtl/cbtr_norm.sv
rtl/cbtr_mask.sv
rtl/cbtr_lane.sv
rtl/color_balance_tone_ranges.sv
tb/tb_top.sv
